>>> hw/rtl/gps_pkg.sv
`default_nettype none

package gps_pkg;

    localparam int LEG_COUNT_DEF     = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int LANE_W            = 16;
    localparam int TIME_W            = 32;
    localparam int LEGS_MAX          = 4;

    typedef enum logic [2:0] {
        ST_SWING  = 3'd0,
        ST_STANCE = 3'd1,
        ST_EARLY  = 3'd2,
        ST_LOST   = 3'd3,
        ST_USER   = 3'd4
    } leg_state_t;

    typedef enum logic [2:0] {
        REG_STANCE    = 3'd0,
        REG_DUTY      = 3'd1,
        REG_PHASE0    = 3'd2,
        REG_INIT_ST   = 3'd3,
        REG_THRESHOLD = 3'd4
    } cfg_reg_t;

    // per-leg view of the configuration registers
    typedef struct packed {
        logic [LANE_W-1:0] stance;
        logic [LANE_W-1:0] duty;
        logic [LANE_W-1:0] phase0;
        logic              swing;
    } lane_cfg_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              contact;
        logic [LANE_W-1:0] phase;
    } lane_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/gps_lane.sv
`default_nettype none

module gps_lane #(
    parameter int FRACTION_BITS = gps_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [gps_pkg::TIME_W-1:0] current_time,
    input  wire logic                      contact,
    input  wire gps_pkg::lane_cfg_t        cfg,
    output gps_pkg::lane_res_t             res
);

    localparam int F  = FRACTION_BITS;
    localparam int SW = gps_pkg::LANE_W;
    localparam int XW = gps_pkg::TIME_W + F + 1;
    localparam int HW = XW - F;
    localparam int PW = SW + F;
    localparam int DW = SW + F + 1;
    localparam int L  = HW + F + 2;

    logic [F-1:0]    d;
    logic [F-1:0]    ip;
    logic [SW-1:0]   s;
    logic [F:0]      r;
    logic [F+SW-1:0] p_phase;
    logic [gps_pkg::TIME_W+F-1:0] p_time;
    logic [XW-1:0]   x_sum;

    assign d       = cfg.duty[F-1:0];
    assign ip      = cfg.phase0[F-1:0];
    assign s       = cfg.stance;
    assign r       = cfg.swing ? ((F+1)'(1) << F) - {1'b0, d} : {1'b0, d};
    assign p_phase = (F+SW)'(ip) * (F+SW)'(s);
    assign p_time  = (gps_pkg::TIME_W+F)'(current_time) * (gps_pkg::TIME_W+F)'(d);
    assign x_sum   = XW'(p_phase) + XW'(p_time);

    // segment lengths scaled by stance; config must stay static while items fly (not enforced here)
    logic [DW-1:0] split_reg;
    logic [DW-1:0] other_reg;

    always_ff @(posedge clk)
    begin
        split_reg <= DW'(r) * DW'(s);
        other_reg <= DW'(((F+1)'(1) << F) - r) * DW'(s);
    end

    logic          v_reg [0:L-1];
    logic          c_reg [0:L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < L; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= contact;
            for (int k = 1; k < L; k++)
            begin
                c_reg[k] <= c_reg[k-1];
            end
        end
    end

    // modulo by stance, one quotient bit a stage
    logic [HW-1:0] hi_reg [0:HW-1];
    logic [F-1:0]  lo_reg [0:HW];
    logic [SW-1:0] rm_reg [0:HW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg[0] <= x_sum[XW-1:F];
            lo_reg[0] <= x_sum[F-1:0];
            rm_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= HW; i++)
    begin : g_mod
        logic [SW:0] tr;
        assign tr = {rm_reg[i-1], hi_reg[i-1][HW-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rm_reg[i] <= (tr >= {1'b0, s}) ? SW'(tr - {1'b0, s}) : tr[SW-1:0];
                lo_reg[i] <= lo_reg[i-1];
            end
        end

        if (i < HW)
        begin : g_hi
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hi_reg[i] <= hi_reg[i-1] << 1;
                end
            end
        end
    end

    // pick segment, then long division for the normalized phase
    logic [PW-1:0] pn;
    logic          in_first;

    assign pn       = {rm_reg[HW], lo_reg[HW]};
    assign in_first = DW'(pn) < split_reg;

    logic [DW-1:0] num_reg [0:F-1];
    logic [DW-1:0] den_reg [0:F-1];
    logic [F-1:0]  q_reg   [0:F];
    logic          fs_reg  [0:F];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= in_first ? DW'(pn) : DW'(pn) - split_reg;
            den_reg[0] <= in_first ? split_reg : other_reg;
            q_reg[0]   <= '0;
            fs_reg[0]  <= in_first;
        end
    end

    for (genvar j = 1; j <= F; j++)
    begin : g_div
        logic [DW:0] tq;
        logic        ge;
        assign tq = {num_reg[j-1], 1'b0};
        assign ge = tq >= {1'b0, den_reg[j-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]  <= {q_reg[j-1][F-2:0], ge};
                fs_reg[j] <= fs_reg[j-1];
            end
        end

        if (j < F)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[j] <= ge ? DW'(tq - {1'b0, den_reg[j-1]}) : tq[DW-1:0];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign res.vld     = v_reg[L-1];
    assign res.contact = c_reg[L-1];
    assign res.first   = fs_reg[F];
    assign res.phase   = SW'(q_reg[F]);

endmodule

`default_nettype wire

>>> hw/rtl/gps_merge.sv
`default_nettype none

module gps_merge #(
    parameter int LEG_COUNT     = gps_pkg::LEG_COUNT_DEF,
    parameter int FRACTION_BITS = gps_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire gps_pkg::lane_res_t           res       [0:gps_pkg::LEGS_MAX-1],
    input  wire gps_pkg::lane_cfg_t           cfg       [0:gps_pkg::LEGS_MAX-1],
    input  wire logic [gps_pkg::LANE_W-1:0]   threshold,
    output logic                              out_valid,
    output logic [2:0]                        state     [0:gps_pkg::LEGS_MAX-1],
    output logic [gps_pkg::LANE_W-1:0]        phase     [0:gps_pkg::LEGS_MAX-1]
);

    localparam int F    = FRACTION_BITS;
    localparam int TINY = (2**F + 999) / 1000;

    logic                       out_valid_reg;
    gps_pkg::leg_state_t        st_next  [0:gps_pkg::LEGS_MAX-1];
    logic [gps_pkg::LANE_W-1:0] ph_next  [0:gps_pkg::LEGS_MAX-1];
    gps_pkg::leg_state_t        st_reg   [0:gps_pkg::LEGS_MAX-1];
    logic [gps_pkg::LANE_W-1:0] ph_reg   [0:gps_pkg::LEGS_MAX-1];

    always_comb
    begin
        for (int k = 0; k < gps_pkg::LEGS_MAX; k++)
        begin
            gps_pkg::leg_state_t first_st;
            gps_pkg::leg_state_t second_st;
            first_st   = cfg[k].swing ? gps_pkg::ST_SWING : gps_pkg::ST_STANCE;
            second_st  = cfg[k].swing ? gps_pkg::ST_STANCE : gps_pkg::ST_SWING;
            st_next[k] = gps_pkg::ST_SWING;
            ph_next[k] = '0;
            if (k < LEG_COUNT)
            begin
                if (cfg[k].duty[F-1:0] < F'(TINY))
                begin
                    st_next[k] = gps_pkg::ST_USER;
                end
                else
                begin
                    if (cfg[k].stance == '0)
                    begin
                        // zero period: sit at the start of the first segment
                        st_next[k] = first_st;
                    end
                    else
                    begin
                        st_next[k] = res[k].first ? first_st : second_st;
                        ph_next[k] = res[k].phase;
                    end
                    if (ph_next[k][F-1:0] >= threshold[F-1:0])
                    begin
                        if (st_next[k] == gps_pkg::ST_SWING && res[k].contact)
                        begin
                            st_next[k] = gps_pkg::ST_EARLY;
                        end
                        else if (st_next[k] == gps_pkg::ST_STANCE && !res[k].contact)
                        begin
                            st_next[k] = gps_pkg::ST_LOST;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= res[0].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < gps_pkg::LEGS_MAX; k++)
            begin
                st_reg[k] <= st_next[k];
                ph_reg[k] <= ph_next[k];
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        for (int k = 0; k < gps_pkg::LEGS_MAX; k++)
        begin
            state[k] = st_reg[k];
            phase[k] = ph_reg[k];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gait_phase_scheduler_unit.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  current_time, foot_contacts
// out       output     out_valid/out_stall  leg0..3_state, leg0..3_phase
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle unless in_stall is high; each leg below LEG_COUNT has
// its own lane pipeline. Stages: a product stage, 33 one-bit stages of the modulo
// by stance, a segment select stage, FRACTION_BITS one-bit division stages and the
// merge output register.
// rst_n clears valid bits and sets configuration to its reset values; data registers are not reset.
// out_stall with a full output register freezes the whole pipeline.
`default_nettype none

module gait_phase_scheduler_unit #(
    parameter int LEG_COUNT     = gps_pkg::LEG_COUNT_DEF,
    parameter int FRACTION_BITS = gps_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [gps_pkg::TIME_W-1:0]    current_time,
    input  wire logic [3:0]                    foot_contacts,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         leg0_state,
    output logic [2:0]                         leg1_state,
    output logic [2:0]                         leg2_state,
    output logic [2:0]                         leg3_state,
    output logic [gps_pkg::LANE_W-1:0]         leg0_phase,
    output logic [gps_pkg::LANE_W-1:0]         leg1_phase,
    output logic [gps_pkg::LANE_W-1:0]         leg2_phase,
    output logic [gps_pkg::LANE_W-1:0]         leg3_phase,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [63:0]                   cfg_data
);

    localparam int SW = gps_pkg::LANE_W;
    localparam int NL = gps_pkg::LEGS_MAX;

    logic [63:0]   stance_reg;
    logic [63:0]   duty_reg;
    logic [63:0]   phase0_reg;
    logic [NL-1:0] init_st_reg;
    logic [SW-1:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stance_reg  <= 64'h012C_012C_012C_012C;
            duty_reg    <= 64'h999A_999A_999A_999A;
            phase0_reg  <= 64'h0000_8000_8000_0000;
            init_st_reg <= '0;
            thr_reg     <= 16'd6554;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gps_pkg::REG_STANCE:    stance_reg  <= cfg_data;
                gps_pkg::REG_DUTY:      duty_reg    <= cfg_data;
                gps_pkg::REG_PHASE0:    phase0_reg  <= cfg_data;
                gps_pkg::REG_INIT_ST:   init_st_reg <= cfg_data[NL-1:0];
                gps_pkg::REG_THRESHOLD: thr_reg     <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    gps_pkg::lane_cfg_t lcfg [0:NL-1];
    gps_pkg::lane_res_t lres [0:NL-1];

    for (genvar k = 0; k < NL; k++)
    begin : g_leg
        assign lcfg[k].stance = stance_reg[SW*k +: SW];
        assign lcfg[k].duty   = duty_reg[SW*k +: SW];
        assign lcfg[k].phase0 = phase0_reg[SW*k +: SW];
        assign lcfg[k].swing  = init_st_reg[k];

        if (k < LEG_COUNT)
        begin : g_lane
            gps_lane #(
                .FRACTION_BITS (FRACTION_BITS)
            ) u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .en           (en),
                .in_valid     (in_valid),
                .current_time (current_time),
                .contact      (foot_contacts[k]),
                .cfg          (lcfg[k]),
                .res          (lres[k])
            );
        end
        else
        begin : g_idle
            assign lres[k] = '0;
        end
    end

    logic [2:0]    st  [0:NL-1];
    logic [SW-1:0] ph  [0:NL-1];

    gps_merge #(
        .LEG_COUNT     (LEG_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .res       (lres),
        .cfg       (lcfg),
        .threshold (thr_reg),
        .out_valid (out_valid),
        .state     (st),
        .phase     (ph)
    );

    assign leg0_state = st[0];
    assign leg1_state = st[1];
    assign leg2_state = st[2];
    assign leg3_state = st[3];
    assign leg0_phase = ph[0];
    assign leg1_phase = ph[1];
    assign leg2_phase = ph[2];
    assign leg3_phase = ph[3];

`ifndef SYNTHESIS
    // stall only while a finished beat is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no waiting output beat");

    a_user_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && leg0_state == gps_pkg::ST_USER) |-> (leg0_phase == '0))
        else $error("user swing leg with nonzero phase");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (leg1_state <= gps_pkg::ST_USER && leg2_state <= gps_pkg::ST_USER))
        else $error("leg state code out of range");
`endif

endmodule

`default_nettype wire
